>>> rtl/hsr_pkg.sv
// Package for the Heron square root core: widths, control-word and status types.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package hsr_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int RADICAND_BITS = 32;
  localparam int ROOT_BITS     = ((RADICAND_BITS - FRACTION_BITS) / 2) + FRACTION_BITS;
  localparam int DIVIDEND_BITS = RADICAND_BITS + FRACTION_BITS;
  localparam int DCNT_BITS     = $clog2(DIVIDEND_BITS);
  localparam int TOL_BITS      = 16;
  localparam int LIMIT_BITS    = 6;
  localparam int CFG_BITS      = 16;
  localparam int STEP_BITS     = 3;

  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(1);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(40);

  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_ZERO,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_ZERO,
    COND_DIV_BUSY,
    COND_GO_ON
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic hold;
    logic zero_in;
    logic div_busy;
    logic go_on;
  } status_t;

endpackage

>>> rtl/hsr_sequencer.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
// Depends on hsr_pkg for control-word and status types.
`timescale 1ns / 1ps

module hsr_sequencer
  import hsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  status_t    status,
  output ctrl_word_t ctrl
);

  localparam step_t S_WAIT   = step_t'(0);
  localparam step_t S_INIT   = step_t'(1);
  localparam step_t S_DIV    = step_t'(2);
  localparam step_t S_UPDATE = step_t'(3);
  localparam step_t S_OUT    = step_t'(4);
  localparam step_t S_ZERO   = step_t'(5);

  step_t step;
  step_t step_next;
  logic  jump;

  always_comb begin
    case (step)
      S_WAIT:   ctrl = '{op: OP_WAIT,     cond: COND_ZERO,     target: S_ZERO};
      S_INIT:   ctrl = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: S_DIV};
      S_DIV:    ctrl = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: S_DIV};
      S_UPDATE: ctrl = '{op: OP_UPDATE,   cond: COND_GO_ON,    target: S_INIT};
      S_OUT:    ctrl = '{op: OP_OUT,      cond: COND_ALWAYS,   target: S_WAIT};
      S_ZERO:   ctrl = '{op: OP_ZERO,     cond: COND_ALWAYS,   target: S_OUT};
      default:  ctrl = '{op: OP_WAIT,     cond: COND_ALWAYS,   target: S_WAIT};
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_ZERO:     jump = status.zero_in;
      COND_DIV_BUSY: jump = status.div_busy;
      COND_GO_ON:    jump = status.go_on;
      default:       jump = 1'b0;
    endcase
    if (status.hold) begin
      step_next = step;
    end else if (jump) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/hsr_datapath.sv
// Datapath: configuration registers, serial restoring divider, estimate update, output word.
// Depends on hsr_pkg; driven by control words from hsr_sequencer.
`timescale 1ns / 1ps

module hsr_datapath
  import hsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RADICAND_BITS-1:0] radicand,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROOT_BITS-1:0]     root,
  output logic [LIMIT_BITS-1:0]    iterations_used,
  output logic                     limit_hit,
  input  ctrl_word_t               ctrl,
  output status_t                  status
);

  localparam logic [DCNT_BITS-1:0] DCNT_LAST = DCNT_BITS'(DIVIDEND_BITS - 1);

  logic [TOL_BITS-1:0]      tolerance;
  logic [LIMIT_BITS-1:0]    limit;
  logic [RADICAND_BITS-1:0] z;
  logic [RADICAND_BITS-1:0] x;
  logic [LIMIT_BITS-1:0]    n;
  logic                     met;
  logic [RADICAND_BITS-1:0] rem;
  logic [DIVIDEND_BITS-1:0] num;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DCNT_BITS-1:0]     dcnt;

  logic [RADICAND_BITS:0]   rem_sh;
  logic                     qbit;
  logic [RADICAND_BITS-1:0] rem_next;
  logic [RADICAND_BITS-1:0] q_sat;
  logic [RADICAND_BITS:0]   sum;
  logic [RADICAND_BITS-1:0] nx;
  logic [RADICAND_BITS-1:0] diff;
  logic                     met_now;
  logic [LIMIT_BITS-1:0]    n_next;
  logic [LIMIT_BITS-1:0]    lim_eff;
  logic [RADICAND_BITS-1:0] x_start;
  logic                     out_free;

  always_comb begin
    rem_sh = {rem, num[DIVIDEND_BITS-1]};
    qbit   = rem_sh >= {1'b0, x};
    rem_next = qbit ? RADICAND_BITS'(rem_sh - {1'b0, x}) : rem_sh[RADICAND_BITS-1:0];
    q_sat  = (|quo[DIVIDEND_BITS-1:RADICAND_BITS]) ? '1 : quo[RADICAND_BITS-1:0];
    sum    = {1'b0, x} + {1'b0, q_sat};
    nx     = sum[RADICAND_BITS:1];
    diff   = (nx >= x) ? (nx - x) : (x - nx);
    met_now = diff <= RADICAND_BITS'(tolerance);
    n_next = n + LIMIT_BITS'(1);
    lim_eff = (limit == '0) ? LIMIT_BITS'(1) : limit;
    x_start = (radicand[RADICAND_BITS-1:1] == '0) ? RADICAND_BITS'(1)
                                                  : {1'b0, radicand[RADICAND_BITS-1:1]};
    out_free = !out_valid || !out_stall;
  end

  assign in_stall = (ctrl.op != OP_WAIT);

  always_comb begin
    status.hold     = ((ctrl.op == OP_WAIT) && !in_valid) ||
                      ((ctrl.op == OP_OUT) && !out_free);
    status.zero_in  = (radicand == '0);
    status.div_busy = (dcnt != DCNT_LAST);
    status.go_on    = !met_now && (n_next < lim_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      limit     <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:  tolerance <= cfg_data[TOL_BITS-1:0];
        REG_ITER_LIMIT: limit     <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_WAIT: begin
        if (in_valid) begin
          z <= radicand;
          x <= x_start;
          n <= '0;
        end
      end
      OP_DIV_INIT: begin
        rem  <= '0;
        num  <= {z, FRACTION_BITS'(0)};
        quo  <= '0;
        dcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= rem_next;
        num  <= {num[DIVIDEND_BITS-2:0], 1'b0};
        quo  <= {quo[DIVIDEND_BITS-2:0], qbit};
        dcnt <= dcnt + DCNT_BITS'(1);
      end
      OP_UPDATE: begin
        x   <= nx;
        n   <= n_next;
        met <= met_now;
      end
      OP_ZERO: begin
        x   <= '0;
        n   <= '0;
        met <= 1'b1;
      end
      OP_OUT: begin
        if (out_free) begin
          root <= (x > RADICAND_BITS'({ROOT_BITS{1'b1}})) ? '1 : x[ROOT_BITS-1:0];
          iterations_used <= n;
          limit_hit <= !met;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/heron_square_root_core.sv
// Top level of the Heron square root core: joins sequencer and datapath.
// Depends on hsr_pkg, hsr_sequencer and hsr_datapath.
//
//   channel   handshake             payload
//   cfg       cfg_we                cfg_index, cfg_data
//   in        in_valid / in_stall   radicand
//   out       out_valid / out_stall root, iterations_used, limit_hit
//
// Each Heron iteration is a divider load, 48 quotient bits from the
// one-bit-per-cycle restoring divider, and the estimate update.
// A zero radicand skips the iterations and goes straight to the output step.
// The result sits in an output register; the next word is taken once it is loaded.
// rst clears the step counter and output valid and sets the configuration registers to defaults.
`timescale 1ns / 1ps

module heron_square_root_core
  import hsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RADICAND_BITS-1:0] radicand,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROOT_BITS-1:0]     root,
  output logic [LIMIT_BITS-1:0]    iterations_used,
  output logic                     limit_hit
);

  ctrl_word_t ctrl;
  status_t    status;

  hsr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  hsr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .radicand        (radicand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .root            (root),
    .iterations_used (iterations_used),
    .limit_hit       (limit_hit),
    .ctrl            (ctrl),
    .status          (status)
  );

endmodule
